>>> rtl/rgbhsl_pkg.sv
`default_nettype none

package rgbhsl_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned SumW    = ChanW + 1;
  localparam int unsigned LightW  = 5;
  localparam int unsigned SatW    = 5;
  localparam int unsigned HueW    = 6;
  localparam int unsigned PackW   = SatW + HueW + LightW;
  localparam int unsigned QuotW   = 6;
  localparam int unsigned SatRemW = ChanW + 5;
  localparam int unsigned SatDenW = SumW;
  localparam int unsigned HueRemW = ChanW + 4;
  localparam int unsigned HueDenW = ChanW;
  localparam int unsigned OffW    = 7;
  localparam int unsigned NumCells = QuotW;

  localparam logic [OffW-1:0] OffRed   = OffW'(64);
  localparam logic [OffW-1:0] OffGreen = OffW'(21);
  localparam logic [OffW-1:0] OffBlue  = OffW'(43);
  localparam logic [SumW:0]   SatTop   = (SumW + 1)'(512);

  typedef struct packed {
    logic                grey;
    logic                low_light;
    logic [LightW-1:0]   light;
    logic [SatRemW-1:0]  sat_rem;
    logic [SatDenW-1:0]  sat_den;
    logic [QuotW-1:0]    sat_q;
    logic [HueRemW-1:0]  hue_rem;
    logic [HueDenW-1:0]  hue_den;
    logic [QuotW-1:0]    hue_q;
    logic                neg;
    logic [OffW-1:0]     offset;
  } stage_t;

endpackage

`default_nettype wire

>>> rtl/rgbhsl_prep.sv
`default_nettype none

module rgbhsl_prep (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [rgbhsl_pkg::ChanW-1:0] red,
  input  wire logic [rgbhsl_pkg::ChanW-1:0] green,
  input  wire logic [rgbhsl_pkg::ChanW-1:0] blue,
  output logic                              valid_out,
  output rgbhsl_pkg::stage_t                stage_out
);
  import rgbhsl_pkg::*;

  logic [ChanW-1:0] mx;
  logic [ChanW-1:0] mn;
  logic [ChanW-1:0] spread;
  logic [ChanW-1:0] pa;
  logic [ChanW-1:0] pb;
  logic [ChanW-1:0] mag;
  logic [SumW-1:0]  sum;
  logic [SumW:0]    upper;
  logic             valid_r;
  stage_t           stage_r;
  stage_t           stage_nxt;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    sum = SumW'(mx) + SumW'(mn);
    spread = mx - mn;
    upper = SatTop - (SumW + 1)'(sum);

    stage_nxt.grey = (mx == mn);
    stage_nxt.light = sum[SumW-1 -: LightW];
    stage_nxt.low_light = ~sum[SumW-1];
    stage_nxt.sat_rem = {spread, 5'b0};
    stage_nxt.sat_den = sum[SumW-1] ? upper[SumW-1:0] : sum;
    stage_nxt.sat_q = '0;

    if (mx == red) begin
      pa = green;
      pb = blue;
      stage_nxt.offset = OffRed;
    end else if (mx == green) begin
      pa = blue;
      pb = red;
      stage_nxt.offset = OffGreen;
    end else begin
      pa = red;
      pb = green;
      stage_nxt.offset = OffBlue;
    end
    stage_nxt.neg = (pa < pb);
    mag = stage_nxt.neg ? (pb - pa) : (pa - pb);
    stage_nxt.hue_rem = (HueRemW'(mag) << 3) + (HueRemW'(mag) << 1) + HueRemW'(mag);
    stage_nxt.hue_den = spread;
    stage_nxt.hue_q = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign valid_out = valid_r;
  assign stage_out = stage_r;

endmodule

`default_nettype wire

>>> rtl/rgbhsl_div_cell.sv
`default_nettype none

module rgbhsl_div_cell #(
  parameter int unsigned QBit = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               valid_in,
  input  wire rgbhsl_pkg::stage_t stage_in,
  output logic                    valid_out,
  output rgbhsl_pkg::stage_t      stage_out
);
  import rgbhsl_pkg::*;

  localparam int unsigned SatCmpW = SatDenW + QuotW;
  localparam int unsigned HueCmpW = HueDenW + QuotW;

  logic [SatCmpW-1:0] sat_div;
  logic [HueCmpW-1:0] hue_div;
  logic               valid_r;
  stage_t             stage_r;
  stage_t             stage_nxt;

  always_comb begin
    stage_nxt = stage_in;
    sat_div = SatCmpW'(stage_in.sat_den) << QBit;
    hue_div = HueCmpW'(stage_in.hue_den) << QBit;
    if (SatCmpW'(stage_in.sat_rem) >= sat_div) begin
      stage_nxt.sat_rem = SatRemW'(SatCmpW'(stage_in.sat_rem) - sat_div);
      stage_nxt.sat_q[QBit] = 1'b1;
    end
    if (HueCmpW'(stage_in.hue_rem) >= hue_div) begin
      stage_nxt.hue_rem = HueRemW'(HueCmpW'(stage_in.hue_rem) - hue_div);
      stage_nxt.hue_q[QBit] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign valid_out = valid_r;
  assign stage_out = stage_r;

endmodule

`default_nettype wire

>>> rtl/rgbhsl_pack.sv
`default_nettype none

module rgbhsl_pack (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          valid_in,
  input  wire rgbhsl_pkg::stage_t            stage_in,
  output logic                               out_valid,
  output logic [rgbhsl_pkg::PackW-1:0]       out_packed_color
);
  import rgbhsl_pkg::*;

  logic [SatW-1:0]  sat;
  logic [OffW-1:0]  hue_full;
  logic [HueW-1:0]  hue;
  logic             valid_r;
  logic [PackW-1:0] packed_r;
  logic [PackW-1:0] packed_nxt;

  always_comb begin
    if (stage_in.low_light) begin
      sat = (stage_in.sat_q == '0) ? '0 : SatW'(stage_in.sat_q - QuotW'(1));
    end else begin
      sat = stage_in.sat_q[SatW-1:0];
    end
    hue_full = stage_in.neg ? (stage_in.offset - OffW'(stage_in.hue_q))
                            : (stage_in.offset + OffW'(stage_in.hue_q));
    hue = hue_full[HueW-1:0];
    if (stage_in.grey) begin
      sat = '0;
      hue = '0;
    end
    packed_nxt = {sat, hue, stage_in.light};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    packed_r <= packed_nxt;
  end

  assign out_valid = valid_r;
  assign out_packed_color = packed_r;

endmodule

`default_nettype wire

>>> rtl/rgb_to_packed_hsl.sv
// A request accepted with start is registered in the prep stage, then in each divider cell
// in turn, and last in the pack stage, whose register drives the result strobe.
// Throughput: one pixel per clock, through a prep stage, six divider cells and a pack stage.
// Each divider cell settles one quotient bit of both the saturation and the hue division.
// The block is never busy, and the receiver cannot stall the result strobe.
// Synchronous active-low reset clears every valid bit; the data path is not reset.
`default_nettype none

module rgb_to_packed_hsl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [rgbhsl_pkg::ChanW-1:0]  in_red,
  input  wire logic [rgbhsl_pkg::ChanW-1:0]  in_green,
  input  wire logic [rgbhsl_pkg::ChanW-1:0]  in_blue,
  output logic                               out_valid,
  output logic [rgbhsl_pkg::PackW-1:0]       out_packed_color
);
  import rgbhsl_pkg::*;

  logic   chain_valid [NumCells+1];
  stage_t chain_stage [NumCells+1];

  assign busy = 1'b0;

  rgbhsl_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .red       (in_red),
    .green     (in_green),
    .blue      (in_blue),
    .valid_out (chain_valid[0]),
    .stage_out (chain_stage[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rgbhsl_div_cell #(
      .QBit (NumCells - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (chain_valid[i]),
      .stage_in  (chain_stage[i]),
      .valid_out (chain_valid[i+1]),
      .stage_out (chain_stage[i+1])
    );
  end

  rgbhsl_pack u_pack (
    .clk              (clk),
    .rst_n            (rst_n),
    .valid_in         (chain_valid[NumCells]),
    .stage_in         (chain_stage[NumCells]),
    .out_valid        (out_valid),
    .out_packed_color (out_packed_color)
  );

endmodule

`default_nettype wire
